@@ hw/rtl/cdq_pkg.sv @@
// cdq_pkg: shared types, constants and helpers for the circular deque unit
// no dependencies; imported by cdq_cell, cdq_chain, circular_deque_unit and tb_top
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int LIMIT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam int LIMIT_RESET   = 16;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PROBE      = 3'd4
  } cmd_t;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic              clear;      // drop all entries
    logic              shift_r;    // move every word one cell toward the rear
    logic              shift_l;    // move every word one cell toward the front
    logic              push_rear;  // first empty cell takes the word
    logic              pop_rear;   // last occupied cell lets go
    logic [DATA_W-1:0] word;
  } cdq_ctl_t;

  // clamp the programmed limit into 1..depth
  function automatic int eff_limit(input logic [LIMIT_W-1:0] lim, input int depth);
    int l;
    l = int'(lim);
    if (l == 0) l = 1;
    if (l > depth) l = depth;
    return l;
  endfunction

endpackage

@@ hw/rtl/cdq_cell.sv @@
// cdq_cell: one slot of the deque chain, holds an occupied flag and a word
// depends on cdq_pkg
module cdq_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_pkg::cdq_ctl_t        ctl,
  input  logic                     left_v,
  input  logic [cdq_pkg::DATA_W-1:0] left_d,
  input  logic                     right_v,
  input  logic [cdq_pkg::DATA_W-1:0] right_d,
  output logic                     v,
  output logic [cdq_pkg::DATA_W-1:0] d,
  output logic                     is_rear
);
  import cdq_pkg::*;

  logic              v_r, v_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    if (ctl.clear) begin
      v_nxt = 1'b0;
    end else if (ctl.shift_r) begin
      v_nxt = left_v;
      d_nxt = left_d;
    end else if (ctl.shift_l) begin
      v_nxt = right_v;
      d_nxt = right_d;
    end else if (ctl.push_rear && !v_r && left_v) begin
      v_nxt = 1'b1;
      d_nxt = ctl.word;
    end else if (ctl.pop_rear && v_r && !right_v) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // data needs no reset, empty cells are never shown
  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign v       = v_r;
  assign d       = d_r;
  assign is_rear = v_r & ~right_v;

endmodule

@@ hw/rtl/cdq_chain.sv @@
// cdq_chain: row of cdq_cell slots, front at cell 0, plus rear word select
// depends on cdq_pkg and cdq_cell
module cdq_chain #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdq_pkg::cdq_ctl_t          ctl,
  output logic                       front_v,
  output logic [cdq_pkg::DATA_W-1:0] front_d,
  output logic [cdq_pkg::DATA_W-1:0] rear_d
);
  import cdq_pkg::*;

  logic [DEPTH-1:0]  v;
  logic [DEPTH-1:0]  rear_sel;
  logic [DATA_W-1:0] d [DEPTH];
  logic [DEPTH-1:0]  rv;
  logic [DATA_W-1:0] rd [DEPTH];
  logic [DATA_W-1:0] lv_d [DEPTH];
  logic [DEPTH-1:0]  lv;

  // neighbor wiring: cell 0 sees the incoming word as an occupied left neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        lv[i]   = 1'b1;
        lv_d[i] = ctl.word;
      end else begin
        lv[i]   = v[i-1];
        lv_d[i] = d[i-1];
      end
      if (i == DEPTH - 1) begin
        rv[i] = 1'b0;
        rd[i] = '0;
      end else begin
        rv[i] = v[i+1];
        rd[i] = d[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cdq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left_v  (lv[g]),
      .left_d  (lv_d[g]),
      .right_v (rv[g]),
      .right_d (rd[g]),
      .v       (v[g]),
      .d       (d[g]),
      .is_rear (rear_sel[g])
    );
  end

  // exactly one cell flags itself as rear when anything is held
  always_comb begin
    rear_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_d = rear_d | (rear_sel[i] ? d[i] : '0);
    end
  end

  assign front_v = v[0];
  assign front_d = d[0];

endmodule

@@ hw/rtl/circular_deque_unit.sv @@
// circular_deque_unit: top level of the double-ended queue of 32-bit words
// depends on cdq_pkg and cdq_chain (which uses cdq_cell)
//
//   channel   ports                            handshake
//   -------   -------------------------------  ---------------------------------
//   command   start, busy, in_command, in_value  taken when start & !busy
//   result    out_valid, out_ok, out_*_value,    one-cycle strobe, no backpressure
//             out_is_empty, out_is_full
//   config    cfg_valid, cfg_ready,              written when cfg_valid & cfg_ready
//             cfg_size_limit
//
// a command is taken every cycle; its result word shows on the cycle after.
// the words are held in the cell registers of the chain: every
// command updates all cells at once, so busy stays low.
// synchronous active-low reset empties the deque and sets the limit to 16
// (clamped to DEPTH); a config write also empties the deque and drops a command taken with it.
// the receiver cannot stall: a result is shown for exactly one cycle.
module circular_deque_unit #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_command,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                        out_valid,
  output logic                        out_ok,
  output logic signed [cdq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [cdq_pkg::DATA_W-1:0] out_rear_value,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cdq_pkg::LIMIT_W-1:0] cfg_size_limit
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          accept;
  logic          cfg_wr;
  cmd_t          cmd;
  cdq_ctl_t      ctl;

  // occupancy and the clamped limit, both in entries
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic          full_now;
  logic          empty_now;
  logic          ok_nxt;

  logic          out_valid_r;
  logic          out_ok_r;

  logic              front_v;
  logic [DATA_W-1:0] front_d;
  logic [DATA_W-1:0] rear_d;

  // every command retires in the edge that takes it
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cmd       = cmd_t'(in_command);

  assign empty_now = (count_r == '0);
  assign full_now  = (count_r == lim_r);

  // decode the command into chain control, refusing pushes when full and pops when empty
  always_comb begin
    ctl           = '0;
    ctl.word      = in_value;
    ctl.clear     = cfg_wr;
    count_nxt     = count_r;
    ok_nxt        = 1'b0;
    lim_nxt       = lim_r;
    if (cfg_wr) begin
      count_nxt = '0;
      lim_nxt   = CW'(eff_limit(cfg_size_limit, DEPTH));
    end else if (accept) begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (!full_now) begin
            ctl.shift_r = 1'b1;
            count_nxt   = count_r + 1'b1;
            ok_nxt      = 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (!full_now) begin
            ctl.push_rear = 1'b1;
            count_nxt     = count_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (!empty_now) begin
            ctl.shift_l = 1'b1;
            count_nxt   = count_r - 1'b1;
            ok_nxt      = 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (!empty_now) begin
            ctl.pop_rear = 1'b1;
            count_nxt    = count_r - 1'b1;
            ok_nxt       = 1'b1;
          end
        end
        CMD_PROBE: begin
          ok_nxt = 1'b1;
        end
        default: begin
          // unknown command: no change, refused
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lim_r       <= CW'(eff_limit(LIMIT_W'(LIMIT_RESET), DEPTH));
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= accept & ~cfg_wr;
      out_ok_r    <= ok_nxt;
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .front_v (front_v),
    .front_d (front_d),
    .rear_d  (rear_d)
  );

  // status is read from the chain and the count register after the command has landed
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_is_empty    = ~front_v;
  assign out_is_full     = full_now;
  assign out_front_value = front_v ? signed'(front_d) : '1;
  assign out_rear_value  = front_v ? signed'(rear_d) : '1;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for circular_deque_unit, a chain-held double-ended queue
// depends on cdq_pkg and the circular_deque_unit rtl; a scoreboard class predicts each word
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam int DEQUE_DEPTH = DEPTH_DEFAULT;
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT = 400;     // cycles with no handshake before giving up
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 83;
  localparam int SETTLE_CYCLES = 3;     // extra wait after the last result word, as a margin
  localparam int REPORT_QUIET = 40;     // stop printing mismatch lines after this many

  // command codes the package leaves undefined; the block must refuse them
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  // what one result word carries
  typedef struct {
    logic              ok;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
  } deque_status_t;

  // scoreboard: keeps a private copy of the ring and its pointers, predicts the status
  // word for every accepted command and checks the words in arrival order
  class deque_scoreboard;
    logic [DATA_W-1:0] ring [0:DEQUE_DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       slot_count;
    deque_status_t     status_q[$];
    int                mismatches;
    int                words_checked;
    int                refused;
    int                full_seen;
    int                limits_used;

    function new();
      foreach (ring[i]) ring[i] = '0;
      mismatches    = 0;
      words_checked = 0;
      refused       = 0;
      full_seen     = 0;
      limits_used   = 1;
      head          = 0;
      tail          = 0;
      slot_count    = LIMIT_RESET + 1;
      if (slot_count > DEQUE_DEPTH + 1) slot_count = DEQUE_DEPTH + 1;
    endfunction

    // a limit write clamps into 1..depth and empties the deque
    function void configure(input logic [LIMIT_W-1:0] lim);
      int unsigned span;
      span = lim;
      if (span == 0) span = 1;
      if (span > DEQUE_DEPTH) span = DEQUE_DEPTH;
      slot_count = span + 1;
      head = 0;
      tail = 0;
      limits_used++;
    endfunction

    function int unsigned step_up(input int unsigned idx);
      return (idx + 1 >= slot_count) ? 0 : idx + 1;
    endfunction

    function int unsigned step_down(input int unsigned idx);
      return (idx == 0) ? slot_count - 1 : idx - 1;
    endfunction

    function int unsigned fill_level();
      return (tail + slot_count - head) % slot_count;
    endfunction

    function int unsigned capacity();
      return slot_count - 1;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // accepted command: apply it to the private ring and queue the expected word
    function void note_command(input logic [2:0] cmd, input logic [DATA_W-1:0] val);
      deque_status_t want;
      bit            was_empty;
      bit            was_full;
      was_empty = (head == tail);
      was_full  = (step_up(tail) == head);
      want.ok   = 1'b0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (!was_full) begin
            head       = step_down(head);
            ring[head] = val;
            want.ok    = 1'b1;
          end else refused++;
        end
        CMD_PUSH_REAR: begin
          if (!was_full) begin
            ring[tail] = val;
            tail       = step_up(tail);
            want.ok    = 1'b1;
          end else refused++;
        end
        CMD_POP_FRONT: begin
          if (!was_empty) begin
            head    = step_up(head);
            want.ok = 1'b1;
          end else refused++;
        end
        CMD_POP_REAR: begin
          if (!was_empty) begin
            tail    = step_down(tail);
            want.ok = 1'b1;
          end else refused++;
        end
        CMD_PROBE: want.ok = 1'b1;
        default: ;
      endcase
      want.empty = (head == tail);
      want.full  = (step_up(tail) == head);
      if (want.empty) begin
        want.front = '1;
        want.rear  = '1;
      end else begin
        want.front = ring[head];
        want.rear  = ring[step_down(tail)];
      end
      if (want.full) full_seen++;
      status_q.push_back(want);
    endfunction

    task report(input string msg);
      if (mismatches < REPORT_QUIET) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(input deque_status_t got);
      deque_status_t want;
      if (status_q.size() == 0) begin
        report("result word with no command pending");
        return;
      end
      want = status_q.pop_front();
      words_checked++;
      if (got.ok !== want.ok)
        report($sformatf("word %0d ok %b, want %b", words_checked, got.ok, want.ok));
      if (got.front !== want.front)
        report($sformatf("word %0d front %h, want %h", words_checked, got.front, want.front));
      if (got.rear !== want.rear)
        report($sformatf("word %0d rear %h, want %h", words_checked, got.rear, want.rear));
      if (got.empty !== want.empty)
        report($sformatf("word %0d empty %b, want %b", words_checked, got.empty, want.empty));
      if (got.full !== want.full)
        report($sformatf("word %0d full %b, want %b", words_checked, got.full, want.full));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [2:0]               in_command;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [LIMIT_W-1:0]       cfg_size_limit;

  deque_scoreboard sb;
  int              stall_cycles;
  bit              filling;   // random walk direction: mostly pushes or mostly pops

  circular_deque_unit #(.DEPTH(DEQUE_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_size_limit  (cfg_size_limit)
  );

  always #(CLK_HALF) clk = ~clk;

  // result monitor: every strobed word goes straight to the scoreboard
  always @(posedge clk) begin
    deque_status_t got;
    if (rst_n && out_valid) begin
      got.ok    = out_ok;
      got.front = out_front_value;
      got.rear  = out_rear_value;
      got.empty = out_is_empty;
      got.full  = out_is_full;
      sb.check_result(got);
    end
  end

  // watchdog: any handshake or result word counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("circular_deque_unit regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one command at the falling edge and hold it until taken
  task issue_command(input logic [2:0] cmd, input logic [DATA_W-1:0] val);
    @(negedge clk);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, val);
  endtask

  // sender goes quiet for the given number of cycles
  task idle_gap(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // limit writes happen only with the deque idle and every word back
  task write_limit(input logic [LIMIT_W-1:0] lim);
    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_size_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.configure(lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly random data, with the sign and all-ones corners now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // push-heavy while filling, pop-heavy while draining, a few probes and bad codes
  function automatic logic [2:0] pick_command(input bit fill_mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_PROBE;
    if (roll < 7) return 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    if (roll < (fill_mode ? 72 : 32))
      return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    return ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  initial begin
    logic [LIMIT_W-1:0] limit_plan [0:PHASES-1];
    logic [2:0]         cmd;
    bit                 quiet;

    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_PROBE;
    in_value       = '0;
    cfg_valid      = 1'b0;
    cfg_size_limit = '0;
    stall_cycles   = 0;
    filling        = 1'b1;

    // smallest, zero (clamps up), all-ones and just past depth (clamp down), then a mix
    limit_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd7, 5'd16, 5'd3, 5'd5, 5'd4};
    limit_plan[7] = LIMIT_W'($urandom_range(0, 31));
    limit_plan[8] = LIMIT_W'($urandom_range(1, 6));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset limit: refusals on empty, corner values at both ends,
    // undefined codes that must leave the deque alone, then draining to empty again
    issue_command(CMD_PROBE, 32'h0);
    issue_command(CMD_POP_FRONT, 32'h0);
    issue_command(CMD_POP_REAR, 32'hffff_ffff);
    issue_command(CMD_PUSH_FRONT, 32'h7fff_ffff);
    issue_command(CMD_PUSH_REAR, 32'h8000_0000);
    issue_command(CMD_PUSH_FRONT, 32'hffff_ffff);
    issue_command(CMD_PUSH_REAR, 32'h0000_0000);
    issue_command(CMD_PROBE, 32'h1234_5678);
    issue_command(CMD_UNUSED_FIRST, 32'hdead_beef);
    issue_command(CMD_UNUSED_MID, 32'h0);
    issue_command(CMD_UNUSED_LAST, 32'hffff_ffff);
    issue_command(CMD_POP_FRONT, 32'h0);
    issue_command(CMD_POP_REAR, 32'h0);
    issue_command(CMD_POP_FRONT, 32'h0);
    issue_command(CMD_POP_REAR, 32'h0);
    issue_command(CMD_POP_REAR, 32'h0);
    issue_command(CMD_PUSH_REAR, 32'h5555_aaaa);
    issue_command(CMD_POP_FRONT, 32'h0);

    // random phases, one limit each; the final phase keeps the sender busy every cycle
    for (int phase = 0; phase < PHASES; phase++) begin
      write_limit(limit_plan[phase]);
      quiet   = (phase == PHASES - 1);
      filling = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!quiet && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 13));
        // turn around at the ends now and then so refusals get exercised too
        if (sb.fill_level() == sb.capacity() && $urandom_range(0, 3) == 0) filling = 1'b0;
        else if (sb.fill_level() == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
        else if ($urandom_range(0, 39) == 0) filling = !filling;
        cmd = pick_command(filling);
        issue_command(cmd, pick_value());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait_drained();

    $display("checked %0d status words across %0d size limits", sb.words_checked,
             sb.limits_used);
    $display("%0d pushes or pops refused, %0d words with the deque full", sb.refused,
             sb.full_seen);
    if (sb.mismatches == 0) begin
      $display("circular_deque_unit regression: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("circular_deque_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/cdq_chain.sv
hw/rtl/circular_deque_unit.sv
verif/tb_top.sv
